### rtl/markup_element_tokenizer_unit_assert.svh
// Assertion macros used by the tokenizer back.
`ifndef MARKUP_ELEMENT_TOKENIZER_UNIT_ASSERT_SVH
`define MARKUP_ELEMENT_TOKENIZER_UNIT_ASSERT_SVH

// The condition must hold whenever the antecedent holds in the same cycle.
`define METU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the antecedent.
`define METU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/metu_pkg.sv
// Shared types, constants and helper functions of the markup element tokenizer.
package metu_pkg;

    // Lookahead window and the widths that follow from it.
    localparam int LOOKAHEAD_DEPTH = 8;
    localparam int CNT_W           = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IDX_W           = $clog2(LOOKAHEAD_DEPTH);
    localparam int MAX_DROP        = 7;

    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(LOOKAHEAD_DEPTH);

    // Queue between the front and the back; a power of two so the pointers wrap.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

    // Characters with a special meaning to the scanner.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_START  = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_CHOOSE = 3'd2,
        MODE_TAG    = 3'd3,
        MODE_TEXT   = 3'd4,
        MODE_NUMREF = 3'd5
    } mode_t;

    // Input word as it arrives.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_doc;
    } in_word_t;

    // Output word as it leaves.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       in_tag;
        logic       element_end;
        logic       last_of_run;
    } out_word_t;

    // Classified word held in the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       store;
        logic       flush;
    } q_word_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic    valid;
        q_word_t word;
    } q_head_t;

    // One result before its end-of-run mark is known.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       tag;
        logic       elem_end;
    } result_t;

    // Write into the output buffer.
    typedef struct packed {
        logic      push;
        out_word_t word;
    } out_push_t;

    // Fold upper case letters to lower case.
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Case-blind compare of a buffer byte against a lower case character.
    function automatic logic ci_eq(input logic [7:0] c, input logic [7:0] ch);
        return to_lower(c) == ch;
    endfunction

endpackage

### rtl/metu_front.sv
// Front: accepts document bytes, classifies them and queues them for the back.
module metu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               doc_valid,
    output logic               doc_ready,
    input  metu_pkg::in_word_t doc_word,
    input  logic               pop,
    output metu_pkg::q_head_t  head
);

    metu_pkg::q_word_t             slots_reg [metu_pkg::QUEUE_DEPTH];
    logic [metu_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [metu_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [metu_pkg::QCNT_W-1:0]   count_reg, count_next;
    metu_pkg::q_word_t             classified;
    logic                          push;
    logic                          take;

    // Classify the incoming byte: a zero is not stored and ends the document.
    always_comb
    begin
        classified.data  = doc_word.in_byte;
        classified.store = doc_word.in_byte != 8'd0;
        classified.flush = (doc_word.in_byte == 8'd0) || doc_word.end_of_doc;
    end

    // Handshake and queue status.
    assign doc_ready  = count_reg != metu_pkg::QUEUE_FULL;
    assign push       = doc_valid && doc_ready;
    assign take       = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.word  = slots_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

### rtl/metu_back.sv
// Back: lookahead buffer and scanner that turns queued bytes into results.
module metu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  metu_pkg::q_head_t   head,
    output logic                pop,
    input  logic                out_full,
    output metu_pkg::out_push_t result
);

    // Scanner state.
    logic [7:0]          buf_reg [metu_pkg::LOOKAHEAD_DEPTH];
    logic [7:0]          buf_next [metu_pkg::LOOKAHEAD_DEPTH];
    metu_pkg::cnt_t      cnt_reg, cnt_next;
    metu_pkg::mode_t     mode_reg, mode_next;
    logic                pws_reg, pws_next;
    logic [1:0]          cdh_reg, cdh_next;
    logic                eopen_reg, eopen_next;
    logic                run_reg, run_next;
    logic                flush_reg, flush_next;

    // Result waiting for its end-of-run mark.
    metu_pkg::result_t   pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_final_reg, pend_final_next;

    // Buffer view after the new byte is written in.
    logic [7:0]          v [metu_pkg::LOOKAHEAD_DEPTH];
    metu_pkg::cnt_t      cnt_v;
    logic                start_run, active, flush_v;
    logic                do_act, do_fin;

    // Outcome of one scanner step.
    metu_pkg::cnt_t      a_drop;
    logic                a_repl;
    logic [7:0]          a_rch;
    logic                a_emit;
    metu_pkg::result_t   a_res;
    metu_pkg::mode_t     a_mode;
    logic                a_pws;
    logic [1:0]          a_cdh;
    logic                a_eopen;

    // Entity matches at the head of the buffer.
    logic                m_nbsp, m_amp, m_lt, m_gt, m_bull, m_quot, m_raquo;
    logic                is_break;

    // Buffer after the drop.
    logic [7:0]          ext [metu_pkg::LOOKAHEAD_DEPTH + metu_pkg::MAX_DROP];
    logic [7:0]          sh [metu_pkg::LOOKAHEAD_DEPTH];
    metu_pkg::cnt_t      post_cnt;

    // Step control.
    logic                new_r;
    metu_pkg::result_t   r;
    logic                push;
    logic                step_en;
    logic                run_end;

    // Take the head word when no run is in progress and write its byte in.
    always_comb
    begin
        start_run = !run_reg && head.valid;
        active    = run_reg || start_run;
        flush_v   = run_reg ? flush_reg : head.word.flush;
        v         = buf_reg;
        cnt_v     = cnt_reg;
        if (start_run && head.word.store && (cnt_reg < metu_pkg::DEPTH_CNT))
        begin
            v[cnt_reg[metu_pkg::IDX_W-1:0]] = head.word.data;
            cnt_v = cnt_reg + metu_pkg::cnt_t'(1);
        end
    end

    // A normal run steps while the window is full; a flush run drains it, then closes.
    assign do_act = active && (flush_v ? (cnt_v != '0) : (cnt_v == metu_pkg::DEPTH_CNT));
    assign do_fin = active && flush_v && (cnt_v == '0);

    // Pattern matches over the window, all in parallel.
    always_comb
    begin
        is_break = (v[0] == metu_pkg::CH_CR) || (v[0] == metu_pkg::CH_LF);
        m_nbsp   = metu_pkg::ci_eq(v[1], "n") && metu_pkg::ci_eq(v[2], "b") &&
                   metu_pkg::ci_eq(v[3], "s") && metu_pkg::ci_eq(v[4], "p") &&
                   (v[5] == metu_pkg::CH_SEMI);
        m_amp    = metu_pkg::ci_eq(v[1], "a") && metu_pkg::ci_eq(v[2], "m") &&
                   metu_pkg::ci_eq(v[3], "p") && (v[4] == metu_pkg::CH_SEMI);
        m_lt     = metu_pkg::ci_eq(v[1], "l") && metu_pkg::ci_eq(v[2], "t");
        m_gt     = metu_pkg::ci_eq(v[1], "g") && metu_pkg::ci_eq(v[2], "t") &&
                   (v[3] == metu_pkg::CH_SEMI);
        m_bull   = metu_pkg::ci_eq(v[1], "b") && metu_pkg::ci_eq(v[2], "u") &&
                   metu_pkg::ci_eq(v[3], "l") && metu_pkg::ci_eq(v[4], "l") &&
                   (v[5] == metu_pkg::CH_SEMI);
        m_quot   = metu_pkg::ci_eq(v[1], "q") && metu_pkg::ci_eq(v[2], "u") &&
                   metu_pkg::ci_eq(v[3], "o") && metu_pkg::ci_eq(v[4], "t") &&
                   (v[5] == metu_pkg::CH_SEMI);
        m_raquo  = metu_pkg::ci_eq(v[1], "r") && metu_pkg::ci_eq(v[2], "a") &&
                   metu_pkg::ci_eq(v[3], "q") && metu_pkg::ci_eq(v[4], "u") &&
                   metu_pkg::ci_eq(v[5], "o") && (v[6] == metu_pkg::CH_SEMI);
    end

    // Next mode and emitted result of one scanner step.
    always_comb
    begin
        a_drop  = '0;
        a_repl  = 1'b0;
        a_rch   = '0;
        a_emit  = 1'b0;
        a_res   = '0;
        a_mode  = mode_reg;
        a_pws   = pws_reg;
        a_cdh   = cdh_reg;
        a_eopen = eopen_reg;
        case (mode_reg)
            metu_pkg::MODE_START:
            begin
                if (is_break || (v[0] == metu_pkg::CH_TAB))
                begin
                    a_drop = metu_pkg::cnt_t'(1);
                end
                else if ((v[0] == metu_pkg::CH_LT) && (v[1] == metu_pkg::CH_BANG) &&
                         (v[2] == metu_pkg::CH_DASH))
                begin
                    a_mode = metu_pkg::MODE_COMMENT;
                    a_cdh  = 2'b00;
                end
                else
                begin
                    a_mode = metu_pkg::MODE_CHOOSE;
                end
            end
            metu_pkg::MODE_COMMENT:
            begin
                a_drop = metu_pkg::cnt_t'(1);
                if ((v[0] == metu_pkg::CH_GT) && (cdh_reg == 2'b11))
                begin
                    a_mode = metu_pkg::MODE_CHOOSE;
                end
                else
                begin
                    a_cdh = {cdh_reg[0], v[0] == metu_pkg::CH_DASH};
                end
            end
            metu_pkg::MODE_CHOOSE:
            begin
                // An exact "&lt;" at element start becomes a tag opener.
                if ((v[0] == metu_pkg::CH_AMP) && (v[1] == "l") && (v[2] == "t") &&
                    (v[3] == metu_pkg::CH_SEMI))
                begin
                    a_drop = metu_pkg::cnt_t'(3);
                    a_repl = 1'b1;
                    a_rch  = metu_pkg::CH_LT;
                end
                else if (v[0] == metu_pkg::CH_LT)
                begin
                    a_drop  = metu_pkg::cnt_t'(1);
                    a_eopen = 1'b1;
                    a_mode  = metu_pkg::MODE_TAG;
                end
                else
                begin
                    a_eopen = 1'b1;
                    a_pws   = 1'b0;
                    a_mode  = metu_pkg::MODE_TEXT;
                end
            end
            metu_pkg::MODE_TAG:
            begin
                if (v[0] == metu_pkg::CH_GT)
                begin
                    a_drop           = metu_pkg::cnt_t'(1);
                    a_emit           = 1'b1;
                    a_res.tag        = 1'b1;
                    a_res.elem_end   = 1'b1;
                    a_eopen          = 1'b0;
                    a_mode           = metu_pkg::MODE_START;
                end
                else if (is_break)
                begin
                    a_drop = metu_pkg::cnt_t'(1);
                end
                else if ((v[0] == metu_pkg::CH_AMP) && m_lt == 1'b0 &&
                         metu_pkg::ci_eq(v[1], "g") && metu_pkg::ci_eq(v[2], "t"))
                begin
                    a_drop = metu_pkg::cnt_t'(3);
                    a_repl = 1'b1;
                    a_rch  = metu_pkg::CH_GT;
                end
                else
                begin
                    a_drop      = metu_pkg::cnt_t'(1);
                    a_emit      = 1'b1;
                    a_res.data  = v[0];
                    a_res.valid = 1'b1;
                    a_res.tag   = 1'b1;
                end
            end
            metu_pkg::MODE_TEXT:
            begin
                if (v[0] == metu_pkg::CH_LT)
                begin
                    a_emit         = 1'b1;
                    a_res.elem_end = 1'b1;
                    a_eopen        = 1'b0;
                    a_mode         = metu_pkg::MODE_START;
                end
                else if (is_break || (v[0] == metu_pkg::CH_TAB))
                begin
                    a_drop = metu_pkg::cnt_t'(1);
                end
                else if (v[0] == metu_pkg::CH_AMP)
                begin
                    // Entities in priority order.
                    if (m_nbsp)
                    begin
                        a_drop = metu_pkg::cnt_t'(6);
                    end
                    else if (m_amp)
                    begin
                        a_drop      = metu_pkg::cnt_t'(5);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_AMP;
                        a_res.valid = 1'b1;
                    end
                    else if (m_lt)
                    begin
                        a_drop = metu_pkg::cnt_t'(3);
                        a_repl = 1'b1;
                        a_rch  = metu_pkg::CH_LT;
                    end
                    else if (m_gt)
                    begin
                        a_drop      = metu_pkg::cnt_t'(4);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_GT;
                        a_res.valid = 1'b1;
                    end
                    else if (m_bull)
                    begin
                        a_drop      = metu_pkg::cnt_t'(6);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_PLUS;
                        a_res.valid = 1'b1;
                    end
                    else if (m_quot)
                    begin
                        a_drop      = metu_pkg::cnt_t'(6);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_QUOTE;
                        a_res.valid = 1'b1;
                    end
                    else if (m_raquo)
                    begin
                        a_drop      = metu_pkg::cnt_t'(7);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_RBRACE;
                        a_res.valid = 1'b1;
                    end
                    else if (v[1] == metu_pkg::CH_HASH)
                    begin
                        a_drop = metu_pkg::cnt_t'(1);
                        a_mode = metu_pkg::MODE_NUMREF;
                    end
                    else
                    begin
                        if (v[1] == metu_pkg::CH_SPACE)
                        begin
                            a_pws = 1'b0;
                        end
                        a_drop      = metu_pkg::cnt_t'(1);
                        a_emit      = 1'b1;
                        a_res.data  = metu_pkg::CH_AMP;
                        a_res.valid = 1'b1;
                    end
                end
                else if (v[0] == metu_pkg::CH_SPACE)
                begin
                    // Only the first space of a run goes out.
                    a_drop = metu_pkg::cnt_t'(1);
                    if (!pws_reg)
                    begin
                        a_pws       = 1'b1;
                        a_emit      = 1'b1;
                        a_res.data  = v[0];
                        a_res.valid = 1'b1;
                    end
                end
                else
                begin
                    a_drop      = metu_pkg::cnt_t'(1);
                    a_pws       = 1'b0;
                    a_emit      = 1'b1;
                    a_res.data  = v[0];
                    a_res.valid = 1'b1;
                end
            end
            metu_pkg::MODE_NUMREF:
            begin
                a_drop = metu_pkg::cnt_t'(1);
                if (v[0] == metu_pkg::CH_SEMI)
                begin
                    a_mode = metu_pkg::MODE_TEXT;
                end
            end
            default:
            begin
                a_mode = metu_pkg::MODE_START;
            end
        endcase
    end

    // Drop the consumed bytes, shift in zeros and apply a head replacement.
    always_comb
    begin
        for (int i = 0; i < metu_pkg::LOOKAHEAD_DEPTH + metu_pkg::MAX_DROP; i++)
        begin
            ext[i] = (i < metu_pkg::LOOKAHEAD_DEPTH) ? v[i % metu_pkg::LOOKAHEAD_DEPTH] : 8'd0;
        end
        for (int i = 0; i < metu_pkg::LOOKAHEAD_DEPTH; i++)
        begin
            sh[i] = 8'd0;
            for (int k = 0; k <= metu_pkg::MAX_DROP; k++)
            begin
                if (a_drop == metu_pkg::cnt_t'(k))
                begin
                    sh[i] = ext[i + k];
                end
            end
        end
        post_cnt = (cnt_v > a_drop) ? (cnt_v - a_drop) : '0;
        if (a_repl && (post_cnt != '0))
        begin
            sh[0] = a_rch;
        end
    end

    // Result of this cycle, pending-result flush and stall control.
    always_comb
    begin
        new_r = (do_act && a_emit) || (do_fin && eopen_reg);
        r     = a_res;
        if (do_fin)
        begin
            r          = '0;
            r.tag      = mode_reg == metu_pkg::MODE_TAG;
            r.elem_end = 1'b1;
        end
        push    = pend_valid_reg && (pend_final_reg || new_r);
        step_en = !push || !out_full;
        run_end = do_fin ||
                  (active && !flush_v && !(do_act && (post_cnt == metu_pkg::DEPTH_CNT)));
        pop     = start_run && step_en;
    end

    // Output word toward the result buffer.
    always_comb
    begin
        result.push             = push && step_en;
        result.word.out_byte    = pend_reg.data;
        result.word.byte_valid  = pend_reg.valid;
        result.word.in_tag      = pend_reg.tag;
        result.word.element_end = pend_reg.elem_end;
        result.word.last_of_run = pend_final_reg;
    end

    // Next state of the scanner and the pending result.
    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        pws_next   = pws_reg;
        cdh_next   = cdh_reg;
        eopen_next = eopen_reg;
        if (do_act)
        begin
            buf_next   = sh;
            cnt_next   = post_cnt;
            mode_next  = a_mode;
            pws_next   = a_pws;
            cdh_next   = a_cdh;
            eopen_next = a_eopen;
        end
        else if (do_fin)
        begin
            for (int i = 0; i < metu_pkg::LOOKAHEAD_DEPTH; i++)
            begin
                buf_next[i] = 8'd0;
            end
            cnt_next   = '0;
            mode_next  = metu_pkg::MODE_START;
            pws_next   = 1'b0;
            cdh_next   = 2'b00;
            eopen_next = 1'b0;
        end
        else if (active)
        begin
            buf_next = v;
            cnt_next = cnt_v;
        end
        run_next   = active && !run_end;
        flush_next = active ? flush_v : flush_reg;

        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg && !push;
        pend_final_next = pend_final_reg;
        if (new_r)
        begin
            pend_next       = r;
            pend_valid_next = 1'b1;
            pend_final_next = run_end;
        end
        else if (run_end)
        begin
            pend_final_next = 1'b1;
        end
    end

    // Scanner and control registers; everything holds while the output is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < metu_pkg::LOOKAHEAD_DEPTH; i++)
            begin
                buf_reg[i] <= 8'd0;
            end
            cnt_reg        <= '0;
            mode_reg       <= metu_pkg::MODE_START;
            pws_reg        <= 1'b0;
            cdh_reg        <= 2'b00;
            eopen_reg      <= 1'b0;
            run_reg        <= 1'b0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
        end
        else if (step_en)
        begin
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            pws_reg        <= pws_next;
            cdh_reg        <= cdh_next;
            eopen_reg      <= eopen_next;
            run_reg        <= run_next;
            flush_reg      <= flush_next;
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
        end
    end

    // Pending result payload.
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            pend_reg <= pend_next;
        end
    end

`include "markup_element_tokenizer_unit_assert.svh"

    // Between runs there is always room for the next byte.
    `METU_ASSERT_SAME(a_idle_room, !run_reg, cnt_reg < metu_pkg::DEPTH_CNT, "window full between runs")
    // A finished document leaves the scanner in its reset state.
    `METU_ASSERT_NEXT(a_flush_clears, do_fin && step_en, (cnt_reg == '0) && (mode_reg == metu_pkg::MODE_START) && !eopen_reg, "scanner not cleared after document end")
    // A result without its end-of-run mark exists only inside a run.
    `METU_ASSERT_SAME(a_open_pend_in_run, pend_valid_reg && !pend_final_reg, run_reg, "unresolved result outside a run")

endmodule

### rtl/metu_out.sv
// Two-word result buffer that decouples the scanner from the output handshake.
module metu_out (
    input  logic                clk,
    input  logic                rst_n,
    input  metu_pkg::out_push_t result,
    output logic                full,
    output logic                tok_valid,
    input  logic                tok_ready,
    output metu_pkg::out_word_t tok_word
);

    metu_pkg::out_word_t slots_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push;
    logic                take;

    // Status and handshake.
    assign full      = count_reg == 2'd2;
    assign tok_valid = count_reg != 2'd0;
    assign tok_word  = slots_reg[rd_ptr_reg];
    assign push      = result.push && !full;
    assign take      = tok_valid && tok_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= result.word;
        end
    end

endmodule

### rtl/markup_element_tokenizer_unit.sv
// Top level of the markup element tokenizer: front, scanner back and result buffer.
// A result word passes the front queue, the pending result register and the result buffer.
// Throughput: one byte per cycle while the result buffer has room and each byte needs one scanner
// step; every further step (mode changes that consume nothing, each extra result) delays the next byte.
// A document end steps once per cycle while not stalled until the window is empty, then closes with a final step.
// Reset is asynchronous and clears the queue, the window, the scanner and the result buffer.
module markup_element_tokenizer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                doc_valid,
    output logic                doc_ready,
    input  metu_pkg::in_word_t  doc_word,
    output logic                tok_valid,
    input  logic                tok_ready,
    output metu_pkg::out_word_t tok_word
);

    metu_pkg::q_head_t   head;
    logic                pop;
    logic                out_full;
    metu_pkg::out_push_t result;

    // Accept and classify bytes.
    metu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .doc_valid (doc_valid),
        .doc_ready (doc_ready),
        .doc_word  (doc_word),
        .pop       (pop),
        .head      (head)
    );

    // Lookahead scanner.
    metu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .out_full (out_full),
        .result   (result)
    );

    // Output buffer.
    metu_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .full      (out_full),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_word  (tok_word)
    );

endmodule
